[design/key_matrix_eager_defer_debounce_defines.svh]
// Assertion macros shared by the debounce block
`ifndef KEY_MATRIX_EAGER_DEFER_DEBOUNCE_DEFINES_SVH
`define KEY_MATRIX_EAGER_DEFER_DEBOUNCE_DEFINES_SVH

// checked only outside reset
`define KMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge
`define KMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/kmd_pkg.sv]
// Types and constants of the key matrix debounce block
package kmd_pkg;

  localparam int ROWS  = 16;
  localparam int COLS  = 16;
  localparam int ROW_W = 4;
  localparam int COL_W = 4;
  localparam int RAW_W = 16;
  localparam int EL_W  = 8;
  localparam int TMR_W = 7;
  localparam int CNT_W = 5;
  localparam int KEYS  = ROWS * COLS;
  localparam int KEY_W = ROW_W + COL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 2'd2;

  localparam logic [TMR_W-1:0] DEBOUNCE_RESET = 7'd5;
  localparam logic [CNT_W-1:0] ROWS_RESET     = 5'd16;
  localparam logic [CNT_W-1:0] COLS_RESET     = 5'd16;
  localparam logic [TMR_W-1:0] TIMER_DONE     = 7'd0;
  localparam logic [CNT_W-1:0] ROWS_MAX       = CNT_W'(ROWS);
  localparam logic [CNT_W-1:0] COLS_MAX       = CNT_W'((COLS < RAW_W) ? COLS : RAW_W);
  localparam logic [KEY_W-1:0] KEY_LAST       = KEY_W'(KEYS - 1);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [RAW_W-1:0] raw;
    logic [EL_W-1:0]  el;
    logic             active;
    logic [CNT_W-1:0] ncols;
    logic [TMR_W-1:0] dv;
  } job_t;

  typedef struct packed {
    logic             flag;
    logic [TMR_W-1:0] timer;
  } key_t;

  typedef struct packed {
    logic             is_event;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             state;
    logic [RAW_W-1:0] drow;
    logic             last;
  } result_t;

endpackage

[design/kmd_front.sv]
// Front end: configuration registers, scan item classification and job queue
module kmd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [kmd_pkg::ROW_W-1:0]      row_index_i,
  input  logic [kmd_pkg::RAW_W-1:0]      raw_row_i,
  input  logic [kmd_pkg::EL_W-1:0]       elapsed_ms_i,
  output logic                           job_valid_o,
  output kmd_pkg::job_t                  job_o,
  input  logic                           job_pop_i
);
  import kmd_pkg::*;

  logic [TMR_W-1:0] debounce_q;
  logic [CNT_W-1:0] rows_q, cols_q;
  logic [CNT_W-1:0] nrows, ncols;
  job_t             job_in;
  job_t             mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             wr_en, rd_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      rows_q     <= ROWS_RESET;
      cols_q     <= COLS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_MS: debounce_q <= cfg_data_i;
        CFG_ACTIVE_ROWS: rows_q     <= cfg_data_i[CNT_W-1:0];
        CFG_ACTIVE_COLS: cols_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nrows         = (rows_q > ROWS_MAX) ? ROWS_MAX : rows_q;
    ncols         = (cols_q > COLS_MAX) ? COLS_MAX : cols_q;
    job_in.row    = row_index_i;
    job_in.raw    = raw_row_i;
    job_in.el     = elapsed_ms_i;
    job_in.active = {1'b0, row_index_i} < nrows;
    job_in.ncols  = job_in.active ? ncols : '0;
    job_in.dv     = (debounce_q == TIMER_DONE) ? TMR_W'(1) : debounce_q;
  end

  assign full        = (cnt_q == 2'd2);
  assign wr_en       = push && !full;
  assign job_valid_o = (cnt_q != 2'd0);
  assign rd_en       = job_pop_i && job_valid_o;
  assign job_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_en) wptr_q <= ~wptr_q;
      if (rd_en) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[design/kmd_back.sv]
// Back end: per-column debounce sequencer with key timers and debounced rows
`include "key_matrix_eager_defer_debounce_defines.svh"
module kmd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  kmd_pkg::job_t    job_i,
  output logic             job_pop_o,
  input  logic             out_full_i,
  output logic             res_push_o,
  output kmd_pkg::result_t res_o
);
  import kmd_pkg::*;

  key_t             key_mem [KEYS];
  key_t             key_rd_q, key_wdata;
  logic [RAW_W-1:0] dm_q    [ROWS];
  logic [CNT_W-1:0] col_q;
  logic [RAW_W-1:0] cooked_q;
  logic             fetched_q;
  logic             clr_q;
  logic [KEY_W-1:0] clr_addr_q;

  logic             go, fetch, closing, ev, st;
  logic             rd_en, wr_en;
  logic [KEY_W-1:0] rd_addr, wr_addr;
  logic [COL_W-1:0] cidx;
  logic [CNT_W-1:0] col_nxt;
  logic [RAW_W-1:0] cooked_cur, cooked_n, stored;
  logic [TMR_W-1:0] t, t_n;
  logic             p, p_n, r, k, k_n;

  always_comb begin
    closing    = (col_q >= job_i.ncols);
    go         = job_valid_i && !clr_q && !out_full_i && (closing || fetched_q);
    fetch      = job_valid_i && !clr_q && !closing && !fetched_q;
    cidx       = col_q[COL_W-1:0];
    col_nxt    = col_q + CNT_W'(1);
    stored     = ({1'b0, job_i.row} < ROWS_MAX) ? dm_q[job_i.row] : '0;
    cooked_cur = (col_q == '0) ? stored : cooked_q;
    t          = key_rd_q.timer;
    p          = key_rd_q.flag;
    r          = job_i.raw[cidx];
    k          = cooked_cur[cidx];
    t_n        = t;
    p_n        = p;
    k_n        = k;
    ev         = 1'b0;
    st         = 1'b0;

    // countdown pass
    if (t != TIMER_DONE) begin
      if ({1'b0, t} <= job_i.el) begin
        t_n = TIMER_DONE;
        if (!p) begin
          k_n = r;
          ev  = 1'b1;
          st  = r;
        end
      end else begin
        t_n = t - job_i.el[TMR_W-1:0];
      end
    end

    // transfer pass
    if (r != k_n) begin
      if (t_n == TIMER_DONE) begin
        p_n = r;
        t_n = job_i.dv;
        if (r) begin
          k_n = 1'b1;
          ev  = 1'b1;
          st  = 1'b1;
        end
      end
    end else if (t_n != TIMER_DONE && !p_n) begin
      t_n = TIMER_DONE;
    end

    cooked_n       = cooked_cur;
    cooked_n[cidx] = k_n;

    // next column is fetched while the current one is walked
    rd_en     = fetch || (go && !closing);
    rd_addr   = {job_i.row, fetch ? cidx : col_nxt[COL_W-1:0]};
    wr_en     = clr_q || (go && !closing);
    wr_addr   = clr_q ? clr_addr_q : {job_i.row, cidx};
    key_wdata = clr_q ? '0 : '{flag: p_n, timer: t_n};

    job_pop_o  = go && closing;
    res_push_o = go && (closing || ev);
    if (closing) begin
      res_o = '{is_event: 1'b0, row: job_i.row, col: '0, state: 1'b0,
                drow: cooked_cur, last: 1'b1};
    end else begin
      res_o = '{is_event: 1'b1, row: job_i.row, col: cidx, state: st,
                drow: cooked_n, last: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) key_mem[wr_addr] <= key_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) key_rd_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      fetched_q  <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      for (int i = 0; i < ROWS; i++) dm_q[i] <= '0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + KEY_W'(1);
        if (clr_addr_q == KEY_LAST) clr_q <= 1'b0;
      end
      if (fetch) begin
        fetched_q <= 1'b1;
      end else if (go) begin
        if (closing) begin
          col_q     <= '0;
          fetched_q <= 1'b0;
          if (job_i.active) dm_q[job_i.row] <= cooked_cur;
        end else begin
          col_q <= col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && !closing) cooked_q <= cooked_n;
  end

  `KMD_ASSERT(a_col_bound, job_valid_i |-> col_q <= job_i.ncols, "column past row width")
  `KMD_ASSERT(a_col_restart, job_pop_o |=> col_q == '0, "column count not restarted")
  `KMD_ASSERT(a_idle_row_quiet, job_valid_i && !job_i.active |-> closing, "event on unused row")
  `KMD_ASSERT_ALWAYS(a_clear_quiet, !(clr_q && (go || fetch)), "sequencer ran while clearing")

endmodule

[design/kmd_outq.sv]
// Result queue between the sequencer and the result ports
module kmd_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kmd_pkg::result_t data_i,
  output logic             full_o,
  output logic             empty,
  input  logic             pop,
  output kmd_pkg::result_t data_o
);
  import kmd_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       wr_en, rd_en;

  assign full_o = (cnt_q == 3'd4);
  assign empty  = (cnt_q == 3'd0);
  assign wr_en  = push_i && !full_o;
  assign rd_en  = pop && !empty;
  assign data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= wptr_q + 2'd1;
      if (rd_en) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

endmodule

[design/key_matrix_eager_defer_debounce.sv]
// Top level of the key matrix debounce block: front end, sequencer, result queue
//
//   channel   handshake            payload
//   config    cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//   scan in   push / full          row_index_i, raw_row_i, elapsed_ms_i
//   result    empty / pop          is_event_o .. last_o
//
// For each item the sequencer first fetches the first key entry, then walks one column
// per cycle while the result queue has room, then emits the closing transaction; an
// unused row gets only the closing transaction.
// A two-entry job queue takes the next scan while the current one is walked.
// The sequencer walks no column and emits nothing whenever the four-entry result queue is full.
// Reset clears the debounced rows at once; a clearing pass then zeroes all 256 key
// timers and flags, and scans wait in the job queue until it ends.
module key_matrix_eager_defer_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [kmd_pkg::ROW_W-1:0]      row_index_i,
  input  logic [kmd_pkg::RAW_W-1:0]      raw_row_i,
  input  logic [kmd_pkg::EL_W-1:0]       elapsed_ms_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           is_event_o,
  output logic [kmd_pkg::ROW_W-1:0]      event_row_o,
  output logic [kmd_pkg::COL_W-1:0]      event_col_o,
  output logic                           event_state_o,
  output logic [kmd_pkg::RAW_W-1:0]      debounced_row_o,
  output logic                           last_o
);
  import kmd_pkg::*;

  logic    job_valid, job_pop, res_push, out_full;
  job_t    job;
  result_t res, head;

  kmd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .row_index_i  (row_index_i),
    .raw_row_i    (raw_row_i),
    .elapsed_ms_i (elapsed_ms_i),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_pop_i    (job_pop)
  );

  kmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  kmd_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (out_full),
    .empty  (empty),
    .pop    (pop),
    .data_o (head)
  );

  assign is_event_o      = head.is_event;
  assign event_row_o     = head.row;
  assign event_col_o     = head.col;
  assign event_state_o   = head.state;
  assign debounced_row_o = head.drow;
  assign last_o          = head.last;

endmodule
